// ----- rtl/core/bmpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpc_pkg
// Shared types, codes and constants of the blind motor position controller.
// ----------------------------------------------------------------------------
package bmpc_pkg;

    // Motion sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_STOP      = 5'b00001,
        ST_PREP_UP   = 5'b00010,
        ST_PREP_DOWN = 5'b00100,
        ST_UP        = 5'b01000,
        ST_DOWN      = 5'b10000
    } t_motion;

    // Command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_UP   = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;
    localparam logic [1:0] CMD_DOWN = 2'd3;

    // Event codes
    localparam logic [1:0] EV_OK         = 2'd0;
    localparam logic [1:0] EV_DOWN_START = 2'd1;
    localparam logic [1:0] EV_UP_START   = 2'd2;
    localparam logic [1:0] EV_RUN_END    = 2'd3;

    // Relay modes (the reserved code behaves as two-phase)
    localparam logic [1:0] MODE_TWO_PHASE  = 2'd0;
    localparam logic [1:0] MODE_INTLK_UP   = 2'd1;
    localparam logic [1:0] MODE_INTLK_DOWN = 2'd2;
    localparam logic [1:0] MODE_RESERVED   = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PER_100MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_UP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_DOWN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERDRIVE_UP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERDRIVE_DOWN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PREPARE_MS     = 3'd7;

    // Widths
    localparam int unsigned LVL_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned QUO_W  = 26;          // (2^32-1)/100 fits in 26 bits
    localparam int unsigned DIST_W = QUO_W + LVL_W;

    // Reset values of the configuration registers
    localparam logic [1:0]       RST_RELAY_MODE     = MODE_TWO_PHASE;
    localparam logic [LVL_W-1:0] RST_STEP_PER_100MS = 16'd218;
    localparam logic [LVL_W-1:0] RST_END_UP         = 16'd2000;
    localparam logic [LVL_W-1:0] RST_END_DOWN       = 16'd63535;
    localparam logic [LVL_W-1:0] RST_OVERDRIVE_UP   = 16'd0;
    localparam logic [LVL_W-1:0] RST_OVERDRIVE_DOWN = 16'd65535;
    localparam logic [LVL_W-1:0] RST_SETTLE_MS      = 16'd1000;
    localparam logic [LVL_W-1:0] RST_PREPARE_MS     = 16'd100;

    localparam logic [LVL_W-1:0] LEVEL_RESET = 16'h8000;
    localparam logic [LVL_W:0]   STOP_MARGIN = 17'd2000;

    // x / 100 == (x * DIV100_MAGIC) >> DIV100_SHIFT for every 32-bit x
    localparam logic [30:0]  DIV100_MAGIC = 31'd1374389535;
    localparam int unsigned  DIV100_SHIFT = 37;

endpackage : bmpc_pkg
`default_nettype wire

// ----- rtl/core/blind_motor_position_controller_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blind_motor_position_controller_core
// Time-estimated blind position controller with relay sequencing.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per transfer. tuser = {forced, cmd}, tdata = now_ms.
//   cmd tick advances the motor sequence (settle, prepare direction, run,
//   stop); up/stop/down only retarget. Each item yields exactly one result
//   on the master stream: tdata = {target, position, direction, power},
//   tuser = event code.
//   Path: the input register loads at the transfer, then the item moves
//   to the quotient register and then to the result register, where its
//   result is valid.
//   Throughput: one item per cycle. The elapsed time / 100 is formed by a
//   reciprocal multiply in the quotient stage, for both possible last-change
//   times (the committed one and the time of the item ahead), and the commit
//   stage picks the right one, so no item waits on the one before it.
//   Stall: each stage advances when the one after it is empty or moving, so
//   bubbles are squeezed out and items keep arriving until all three stages
//   are full while the master side is held.
//   Reset (i_rst_n low, synchronous): pipeline emptied, sequencer at stop,
//   level and target at mid-travel, relays off, registers at defaults.
//   Configuration writes take effect at once; issue only when idle (unenforced).
// ----------------------------------------------------------------------------
module blind_motor_position_controller_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] now_ms
    input  wire logic [2:0]  i_s_axis_tuser,   // [1:0] cmd, [2] forced
    // master stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [0] relay_power, [1] relay_direction,
                                               // [17:2] position, [33:18] target,
                                               // [39:34] zero
    output logic [1:0]       o_m_axis_tuser,   // [1:0] event_res
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    localparam int unsigned LW = bmpc_pkg::LVL_W;
    localparam int unsigned TW = bmpc_pkg::TIME_W;
    localparam int unsigned QW = bmpc_pkg::QUO_W;
    localparam int unsigned DW = bmpc_pkg::DIST_W;

    // ---------------- configuration registers ----------------
    logic [1:0]    r_mode;
    logic [LW-1:0] r_step, r_end_up, r_end_dn, r_od_up, r_od_dn, r_settle, r_prep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= bmpc_pkg::RST_RELAY_MODE;
            r_step   <= bmpc_pkg::RST_STEP_PER_100MS;
            r_end_up <= bmpc_pkg::RST_END_UP;
            r_end_dn <= bmpc_pkg::RST_END_DOWN;
            r_od_up  <= bmpc_pkg::RST_OVERDRIVE_UP;
            r_od_dn  <= bmpc_pkg::RST_OVERDRIVE_DOWN;
            r_settle <= bmpc_pkg::RST_SETTLE_MS;
            r_prep   <= bmpc_pkg::RST_PREPARE_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bmpc_pkg::CFG_RELAY_MODE:     r_mode   <= i_cfg_data[1:0];
                bmpc_pkg::CFG_STEP_PER_100MS: r_step   <= i_cfg_data;
                bmpc_pkg::CFG_END_UP:         r_end_up <= i_cfg_data;
                bmpc_pkg::CFG_END_DOWN:       r_end_dn <= i_cfg_data;
                bmpc_pkg::CFG_OVERDRIVE_UP:   r_od_up  <= i_cfg_data;
                bmpc_pkg::CFG_OVERDRIVE_DOWN: r_od_dn  <= i_cfg_data;
                bmpc_pkg::CFG_SETTLE_MS:      r_settle <= i_cfg_data;
                bmpc_pkg::CFG_PREPARE_MS:     r_prep   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- controller state ----------------
    bmpc_pkg::t_motion r_state, n_state;
    logic [LW-1:0]     r_kl, n_kl;          // known level
    logic [LW-1:0]     r_tl, n_tl;          // target level
    logic [TW-1:0]     r_last, n_last;      // last change time
    logic              r_pwr, n_pwr;
    logic              r_dir, n_dir;

    // ---------------- pipeline control ----------------
    logic r_v0, r_v1, r_ov;
    logic w_en_out, w_en1, w_en0;

    assign w_en_out        = !r_ov || i_m_axis_tready;
    assign w_en1           = !r_v1 || w_en_out;
    assign w_en0           = !r_v0 || w_en1;
    assign o_s_axis_tready = w_en0;

    // ---------------- stage 0: input register ----------------
    logic [1:0]    r_cmd0;
    logic          r_forced0;
    logic [TW-1:0] r_now0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en0) begin
            r_v0 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_cmd0    <= i_s_axis_tuser[1:0];
            r_forced0 <= i_s_axis_tuser[2];
            r_now0    <= i_s_axis_tdata;
        end
    end

    // ---------------- stage 0 -> 1: elapsed / 100 candidates ----------------
    // Candidate a: last change time stays as committed now.
    // Candidate b: the item ahead (in stage 1) sets it to its own time.
    logic [1:0]    r_cmd1;
    logic          r_forced1;
    logic [TW-1:0] r_now1, r_t_a, r_t_b;
    logic [QW-1:0] r_q_a, r_q_b;
    logic [TW-1:0] w_el_a, w_el_b;
    logic [QW-1:0] w_q_a, w_q_b;

    assign w_el_a = r_now0 - r_last;
    assign w_el_b = r_now0 - r_now1;

    bmpc_div100 u_div_a (.i_dividend(w_el_a), .o_quotient(w_q_a));
    bmpc_div100 u_div_b (.i_dividend(w_el_b), .o_quotient(w_q_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_cmd1    <= r_cmd0;
            r_forced1 <= r_forced0;
            r_now1    <= r_now0;
            r_t_a     <= r_last;
            r_t_b     <= r_now1;
            r_q_a     <= w_q_a;
            r_q_b     <= w_q_b;
        end
    end

    // ---------------- stage 1: estimate and sequencer ----------------
    logic [1:0]    w_mode;
    logic [QW-1:0] w_q;
    logic [DW-1:0] w_dist;
    logic [DW:0]   w_sum_dn;
    logic [TW-1:0] w_el;
    logic [LW-1:0] w_p_up, w_p_dn, w_est_up, w_est_dn, w_est;
    logic          w_halt, w_halt_normal;
    logic [LW-1:0] w_pos_out;
    logic [1:0]    w_ev;

    assign w_mode = (r_mode == bmpc_pkg::MODE_RESERVED) ? bmpc_pkg::MODE_TWO_PHASE : r_mode;
    assign w_q    = (r_last == r_t_a) ? r_q_a : r_q_b;
    assign w_dist = DW'(w_q) * DW'(r_step);
    assign w_el   = r_now1 - r_last;

    // position estimate of the committed state at this item's time
    assign w_p_up   = (w_dist >= DW'(r_kl)) ? '0 : (r_kl - w_dist[LW-1:0]);
    assign w_est_up = (w_p_up < r_od_up) ? r_od_up : w_p_up;
    assign w_sum_dn = {1'b0, w_dist} + (DW+1)'(r_kl);
    assign w_p_dn   = (|w_sum_dn[DW:LW]) ? '1 : w_sum_dn[LW-1:0];
    assign w_est_dn = (w_p_dn > r_od_dn) ? r_od_dn : w_p_dn;

    always_comb begin
        if (r_state == bmpc_pkg::ST_UP) begin
            w_est = w_est_up;
        end else if (r_state == bmpc_pkg::ST_DOWN) begin
            w_est = w_est_dn;
        end else begin
            w_est = r_kl;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_kl          = r_kl;
        n_tl          = r_tl;
        n_last        = r_last;
        n_pwr         = r_pwr;
        n_dir         = r_dir;
        w_ev          = bmpc_pkg::EV_OK;
        w_halt        = 1'b0;
        w_halt_normal = 1'b0;

        if (r_cmd1 == bmpc_pkg::CMD_TICK) begin
            if (r_state == bmpc_pkg::ST_STOP && w_el >= TW'(r_settle)) begin
                if (r_tl > r_kl) begin
                    n_state = bmpc_pkg::ST_PREP_DOWN;
                    n_last  = r_now1;
                    if (w_mode == bmpc_pkg::MODE_INTLK_UP) begin
                        n_dir = 1'b0;
                    end else if (w_mode == bmpc_pkg::MODE_INTLK_DOWN) begin
                        n_dir = 1'b1;
                    end
                end else if (r_tl < r_kl) begin
                    n_state = bmpc_pkg::ST_PREP_UP;
                    n_last  = r_now1;
                    if (w_mode == bmpc_pkg::MODE_INTLK_UP) begin
                        n_dir = 1'b1;
                    end else if (w_mode == bmpc_pkg::MODE_INTLK_DOWN) begin
                        n_dir = 1'b0;
                    end
                end else begin
                    n_pwr = 1'b0;
                    n_dir = 1'b0;
                end
            end else if (r_state == bmpc_pkg::ST_PREP_DOWN && w_el >= TW'(r_prep)) begin
                n_state = bmpc_pkg::ST_DOWN;
                n_last  = r_now1;
                w_ev    = bmpc_pkg::EV_DOWN_START;
                unique case (w_mode)
                    bmpc_pkg::MODE_INTLK_UP: begin
                        n_pwr = 1'b1;
                        n_dir = 1'b0;
                    end
                    bmpc_pkg::MODE_INTLK_DOWN: begin
                        n_pwr = 1'b1;
                        n_dir = 1'b1;
                    end
                    default: begin
                        n_pwr = 1'b0;
                        n_dir = 1'b1;
                    end
                endcase
            end else if (r_state == bmpc_pkg::ST_PREP_UP && w_el >= TW'(r_prep)) begin
                n_state = bmpc_pkg::ST_UP;
                n_last  = r_now1;
                w_ev    = bmpc_pkg::EV_UP_START;
                n_pwr   = 1'b1;
                n_dir   = (w_mode == bmpc_pkg::MODE_INTLK_UP);
            end else if (r_state == bmpc_pkg::ST_UP && w_est <= r_tl) begin
                w_halt        = 1'b1;
                w_halt_normal = ({1'b0, w_est} + bmpc_pkg::STOP_MARGIN) > {1'b0, r_tl};
            end else if (r_state == bmpc_pkg::ST_DOWN && w_est >= r_tl) begin
                w_halt        = 1'b1;
                w_halt_normal = {1'b0, w_est} < ({1'b0, r_tl} + bmpc_pkg::STOP_MARGIN);
            end

            if (w_halt) begin
                w_ev    = bmpc_pkg::EV_RUN_END;
                n_state = bmpc_pkg::ST_STOP;
                n_last  = r_now1;
                n_pwr   = 1'b0;
                if (w_mode == bmpc_pkg::MODE_TWO_PHASE) begin
                    n_dir = 1'b0;
                end
                if (w_halt_normal) begin
                    // normal stop: level clamped into the end positions
                    if (w_est > r_end_dn) begin
                        n_kl = r_end_dn;
                    end else if (w_est < r_end_up) begin
                        n_kl = r_end_up;
                    end else begin
                        n_kl = w_est;
                    end
                    n_tl = n_kl;
                end else begin
                    // reverse stop: raw estimate, target kept
                    n_kl = w_est;
                end
            end
        end else if (r_cmd1 == bmpc_pkg::CMD_STOP || r_state != bmpc_pkg::ST_STOP) begin
            n_tl = w_est;
        end else if (r_cmd1 == bmpc_pkg::CMD_UP) begin
            n_tl = (!r_forced1 && r_kl <= r_end_up) ? r_od_dn : r_od_up;
        end else begin
            n_tl = (!r_forced1 && r_kl >= r_end_dn) ? r_od_up : r_od_dn;
        end
    end

    // Reported position: after a state change no time has run yet, so only
    // the overdrive clamp of a fresh run applies.
    always_comb begin
        if (n_state == r_state) begin
            w_pos_out = w_est;
        end else if (n_state == bmpc_pkg::ST_UP) begin
            w_pos_out = (n_kl < r_od_up) ? r_od_up : n_kl;
        end else if (n_state == bmpc_pkg::ST_DOWN) begin
            w_pos_out = (n_kl > r_od_dn) ? r_od_dn : n_kl;
        end else begin
            w_pos_out = n_kl;
        end
    end

    // commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmpc_pkg::ST_STOP;
            r_kl    <= bmpc_pkg::LEVEL_RESET;
            r_tl    <= bmpc_pkg::LEVEL_RESET;
            r_last  <= '0;
            r_pwr   <= 1'b0;
            r_dir   <= 1'b0;
        end else if (r_v1 && w_en_out) begin
            r_state <= n_state;
            r_kl    <= n_kl;
            r_tl    <= n_tl;
            r_last  <= n_last;
            r_pwr   <= n_pwr;
            r_dir   <= n_dir;
        end
    end

    // ---------------- result register ----------------
    logic [39:0] r_out_data;
    logic [1:0]  r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en_out) begin
            r_ov <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_data <= {6'd0, n_tl, w_pos_out, n_dir, n_pwr};
            r_out_user <= w_ev;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    // the committed last-change time is always one of the two candidates
    a_last_candidate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_last == r_t_a || r_last == r_t_b))
        else $error("last change time matches neither quotient candidate");

    // the power relay is only active during a run
    a_power_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pwr |-> (r_state == bmpc_pkg::ST_UP || r_state == bmpc_pkg::ST_DOWN))
        else $error("power relay active outside a run");

    // a stalled item in the quotient stage is held, not lost
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_en_out) |=> (r_v1 && $stable(r_now1) && $stable(r_cmd1)))
        else $error("stalled mid-stage item changed");
`endif

endmodule : blind_motor_position_controller_core
`default_nettype wire

// ----- rtl/core/bmpc_div100.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpc_div100
// Divide a 32-bit millisecond interval by 100 with a reciprocal multiply.
// ----------------------------------------------------------------------------
module bmpc_div100 (
    input  wire logic [bmpc_pkg::TIME_W-1:0] i_dividend,
    output logic      [bmpc_pkg::QUO_W-1:0]  o_quotient
);

    logic [63:0] w_prod;

    assign w_prod     = 64'(i_dividend) * 64'(bmpc_pkg::DIV100_MAGIC);
    assign o_quotient = w_prod[bmpc_pkg::DIV100_SHIFT +: bmpc_pkg::QUO_W];

endmodule : bmpc_div100
`default_nettype wire

// ----- tb/bmpc_status_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_status_checker
// Follows the item, result and register ports of the blind controller. It
// keeps its own model of the motor sequencer and compares each result
// transfer, field by field, with the oldest predicted status.
// ----------------------------------------------------------------------------
module bmpc_status_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,     // [31:0] now_ms
    input  logic [2:0]  i_in_user,     // [1:0] cmd, [2] forced
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,    // [0] power, [1] direction, [17:2] position,
                                       // [33:18] target, [39:34] zero
    input  logic [1:0]  i_out_user,    // [1:0] event
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_checked,
    output int          o_run_starts,
    output int          o_run_ends
);

    localparam int          RUN_END_MARGIN = 2000;
    localparam int unsigned STEP_MS        = 100;
    localparam int unsigned LW             = bmpc_pkg::LVL_W;
    localparam int unsigned TW             = bmpc_pkg::TIME_W;

    typedef struct packed {
        logic          power;
        logic          direction;
        logic [LW-1:0] position;
        logic [LW-1:0] target;
        logic [1:0]    ev_code;
    } t_relay_status;

    // register copy
    logic [1:0]    relay_mode;
    logic [LW-1:0] step_size;
    logic [LW-1:0] end_up;
    logic [LW-1:0] end_down;
    logic [LW-1:0] od_up;
    logic [LW-1:0] od_down;
    logic [LW-1:0] settle_ms;
    logic [LW-1:0] prepare_ms;

    // sequencer copy
    bmpc_pkg::t_motion motion;
    logic [LW-1:0]     known_level;
    logic [LW-1:0]     target_level;
    logic [TW-1:0]     last_change_ms;
    logic              power_on;
    logic              direction_on;

    t_relay_status awaited_status[$];
    int mismatches = 0;
    int checked    = 0;
    int run_starts = 0;
    int run_ends   = 0;

    // Position estimate: whole 100 ms steps since the last change, saturated
    // at the travel ends, then held inside the overdrive limits.
    function automatic logic [LW-1:0] estimate_level(input logic [TW-1:0] now_ms);
        logic [TW-1:0] elapsed;
        logic [25:0]   steps;
        logic [41:0]   travel;
        logic [42:0]   sum;
        logic [LW-1:0] lvl;
        elapsed = now_ms - last_change_ms;
        steps   = 26'(elapsed / STEP_MS);
        travel  = steps * step_size;
        if (motion == bmpc_pkg::ST_UP) begin
            lvl = (travel >= known_level) ? '0 : known_level - travel[LW-1:0];
            return (lvl < od_up) ? od_up : lvl;
        end
        if (motion == bmpc_pkg::ST_DOWN) begin
            sum = known_level + travel;
            lvl = (sum > 43'd65535) ? 16'hFFFF : sum[LW-1:0];
            return (lvl > od_down) ? od_down : lvl;
        end
        return known_level;
    endfunction

    // Normal stop clamps to the end positions and retargets; a reverse stop
    // keeps the raw estimate and the old target.
    function automatic void stop_run(input logic [TW-1:0] now_ms,
                                     input logic [LW-1:0] pos, input logic normal);
        if (normal) begin
            if (pos > end_down)    known_level = end_down;
            else if (pos < end_up) known_level = end_up;
            else                   known_level = pos;
            target_level = known_level;
        end else begin
            known_level = pos;
        end
        motion         = bmpc_pkg::ST_STOP;
        last_change_ms = now_ms;
        power_on       = 1'b0;
        if (relay_mode == bmpc_pkg::MODE_TWO_PHASE || relay_mode == bmpc_pkg::MODE_RESERVED)
            direction_on = 1'b0;
    endfunction

    function automatic logic [1:0] sequence_tick(input logic [TW-1:0] now_ms);
        logic [TW-1:0] elapsed;
        logic [1:0]    mode;
        logic [LW-1:0] pos;
        int            pos_i;
        int            tgt_i;
        elapsed = now_ms - last_change_ms;
        mode    = (relay_mode == bmpc_pkg::MODE_RESERVED) ? bmpc_pkg::MODE_TWO_PHASE
                                                          : relay_mode;
        if (motion == bmpc_pkg::ST_STOP && elapsed >= settle_ms) begin
            if (target_level > known_level) begin
                motion         = bmpc_pkg::ST_PREP_DOWN;
                last_change_ms = now_ms;
                if (mode == bmpc_pkg::MODE_INTLK_UP)        direction_on = 1'b0;
                else if (mode == bmpc_pkg::MODE_INTLK_DOWN) direction_on = 1'b1;
            end else if (target_level < known_level) begin
                motion         = bmpc_pkg::ST_PREP_UP;
                last_change_ms = now_ms;
                if (mode == bmpc_pkg::MODE_INTLK_UP)        direction_on = 1'b1;
                else if (mode == bmpc_pkg::MODE_INTLK_DOWN) direction_on = 1'b0;
            end else begin
                power_on     = 1'b0;
                direction_on = 1'b0;
            end
            return bmpc_pkg::EV_OK;
        end
        if (motion == bmpc_pkg::ST_PREP_DOWN && elapsed >= prepare_ms) begin
            motion         = bmpc_pkg::ST_DOWN;
            last_change_ms = now_ms;
            power_on       = (mode != bmpc_pkg::MODE_TWO_PHASE);
            direction_on   = (mode != bmpc_pkg::MODE_INTLK_UP);
            return bmpc_pkg::EV_DOWN_START;
        end
        if (motion == bmpc_pkg::ST_PREP_UP && elapsed >= prepare_ms) begin
            motion         = bmpc_pkg::ST_UP;
            last_change_ms = now_ms;
            power_on       = 1'b1;
            direction_on   = (mode == bmpc_pkg::MODE_INTLK_UP);
            return bmpc_pkg::EV_UP_START;
        end
        pos   = estimate_level(now_ms);
        pos_i = int'(pos);
        tgt_i = int'(target_level);
        if (motion == bmpc_pkg::ST_UP && pos <= target_level) begin
            stop_run(now_ms, pos, pos_i > tgt_i - RUN_END_MARGIN);
            return bmpc_pkg::EV_RUN_END;
        end
        if (motion == bmpc_pkg::ST_DOWN && pos >= target_level) begin
            stop_run(now_ms, pos, pos_i < tgt_i + RUN_END_MARGIN);
            return bmpc_pkg::EV_RUN_END;
        end
        return bmpc_pkg::EV_OK;
    endfunction

    task automatic predict_status(input logic [1:0] cmd, input logic forced,
                                  input logic [TW-1:0] now_ms);
        t_relay_status st;
        logic [1:0]    ev;
        ev = bmpc_pkg::EV_OK;
        if (cmd == bmpc_pkg::CMD_TICK)
            ev = sequence_tick(now_ms);
        else if (cmd == bmpc_pkg::CMD_STOP || motion != bmpc_pkg::ST_STOP)
            target_level = estimate_level(now_ms);
        else if (cmd == bmpc_pkg::CMD_UP)
            target_level = (!forced && known_level <= end_up) ? od_down : od_up;
        else
            target_level = (!forced && known_level >= end_down) ? od_up : od_down;
        if (ev == bmpc_pkg::EV_DOWN_START || ev == bmpc_pkg::EV_UP_START) run_starts++;
        if (ev == bmpc_pkg::EV_RUN_END) run_ends++;
        st.power     = power_on;
        st.direction = direction_on;
        st.position  = estimate_level(now_ms);
        st.target    = target_level;
        st.ev_code   = ev;
        awaited_status.push_back(st);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] result %0d: %s is %0d, expected %0d",
                 $realtime, checked, field, got, want);
    endtask

    always @(posedge i_clk) begin : track
        t_relay_status want;
        if (!i_rst_n) begin
            relay_mode     = bmpc_pkg::RST_RELAY_MODE;
            step_size      = bmpc_pkg::RST_STEP_PER_100MS;
            end_up         = bmpc_pkg::RST_END_UP;
            end_down       = bmpc_pkg::RST_END_DOWN;
            od_up          = bmpc_pkg::RST_OVERDRIVE_UP;
            od_down        = bmpc_pkg::RST_OVERDRIVE_DOWN;
            settle_ms      = bmpc_pkg::RST_SETTLE_MS;
            prepare_ms     = bmpc_pkg::RST_PREPARE_MS;
            motion         = bmpc_pkg::ST_STOP;
            known_level    = bmpc_pkg::LEVEL_RESET;
            target_level   = bmpc_pkg::LEVEL_RESET;
            last_change_ms = '0;
            power_on       = 1'b0;
            direction_on   = 1'b0;
            awaited_status.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bmpc_pkg::CFG_RELAY_MODE:     relay_mode = i_cfg_data[1:0];
                    bmpc_pkg::CFG_STEP_PER_100MS: step_size  = i_cfg_data;
                    bmpc_pkg::CFG_END_UP:         end_up     = i_cfg_data;
                    bmpc_pkg::CFG_END_DOWN:       end_down   = i_cfg_data;
                    bmpc_pkg::CFG_OVERDRIVE_UP:   od_up      = i_cfg_data;
                    bmpc_pkg::CFG_OVERDRIVE_DOWN: od_down    = i_cfg_data;
                    bmpc_pkg::CFG_SETTLE_MS:      settle_ms  = i_cfg_data;
                    bmpc_pkg::CFG_PREPARE_MS:     prepare_ms = i_cfg_data;
                    default: ;
                endcase
            end
            // results first: an item taken this edge cannot have its result out yet
            if (i_out_valid && i_out_ready) begin
                if (awaited_status.size() == 0) begin
                    report_mismatch("unrequested result, tdata[31:0]", i_out_data[31:0], 0);
                end else begin
                    want = awaited_status.pop_front();
                    if (i_out_data[0] !== want.power)
                        report_mismatch("relay_power", 32'(i_out_data[0]),
                                        32'(want.power));
                    if (i_out_data[1] !== want.direction)
                        report_mismatch("relay_direction", 32'(i_out_data[1]),
                                        32'(want.direction));
                    if (i_out_data[17:2] !== want.position)
                        report_mismatch("position", 32'(i_out_data[17:2]),
                                        32'(want.position));
                    if (i_out_data[33:18] !== want.target)
                        report_mismatch("target", 32'(i_out_data[33:18]),
                                        32'(want.target));
                    if (i_out_data[39:34] !== 6'd0)
                        report_mismatch("tdata padding", 32'(i_out_data[39:34]), 0);
                    if (i_out_user !== want.ev_code)
                        report_mismatch("event_res", 32'(i_out_user), 32'(want.ev_code));
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready)
                predict_status(i_in_user[1:0], i_in_user[2], i_in_data);
        end
        o_mismatches  <= mismatches;
        o_outstanding <= awaited_status.size();
        o_checked     <= checked;
        o_run_starts  <= run_starts;
        o_run_ends    <= run_ends;
    end

endmodule

// ----- tb/blind_motor_position_controller_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blind_motor_position_controller_core_tb
// Drives tick and up/stop/down items through the blind controller under
// several register settings, with random gaps on both streams and one long
// receiver hold. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module blind_motor_position_controller_core_tb;

    localparam int CYCLE_LIMIT     = 400000;  // far above the slowest correct run
    localparam int ITEMS_PER_PHASE = 260;
    localparam int RX_HOLD_CYCLES  = 150;     // long enough to back up all stages
    localparam int TAIL_CYCLES     = 8;       // idle wait after the last drain

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;            // [31:0] now_ms
    logic [2:0]  s_tuser     = '0;            // [1:0] cmd, [2] forced
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;                     // [0] power, [1] direction,
                                              // [17:2] position, [33:18] target
    logic [1:0]  m_tuser;                     // [1:0] event_res
    logic        cfg_we      = 1'b0;
    logic [2:0]  cfg_idx     = '0;
    logic [15:0] cfg_data    = '0;

    // stimulus knobs
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        rx_hold       = 1'b0;
    logic        pressure_go   = 1'b0;
    logic [31:0] clock_ms      = '0;          // running millisecond time base
    int          items_sent    = 0;
    int          settings_done = 0;
    int          cycle_count   = 0;

    int mismatches;
    int outstanding;
    int checked;
    int run_starts;
    int run_ends;

    always #2 clk = ~clk;

    blind_motor_position_controller_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    bmpc_status_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (s_tvalid),
        .i_in_ready    (s_tready),
        .i_in_data     (s_tdata),
        .i_in_user     (s_tuser),
        .i_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .i_out_data    (m_tdata),
        .i_out_user    (m_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_run_starts  (run_starts),
        .o_run_ends    (run_ends)
    );

    // Result side: random back-pressure, or a solid hold while rx_hold is up.
    always @(posedge clk) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver hold, timed here so the sender keeps offering meanwhile
    // and the pipeline fills up and drops tready on the item side.
    initial begin
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycle_count, outstanding);
        $display("TB_ERROR");
        $finish;
    end

    // One item transfer. tvalid stays high from one item to the next unless
    // a random gap is inserted, so it is never dropped and raised in one step.
    task automatic send_item(input logic [1:0] cmd, input logic forced,
                             input logic [31:0] now_ms);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {forced, cmd};
        s_tdata  <= now_ms;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain_results;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Leaves cfg_we high; program_settings drops it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic program_settings(input logic [1:0] mode, input logic [15:0] step,
                                    input logic [15:0] top_end, input logic [15:0] bottom_end,
                                    input logic [15:0] top_od, input logic [15:0] bottom_od,
                                    input logic [15:0] settle, input logic [15:0] prepare);
        write_reg(bmpc_pkg::CFG_RELAY_MODE,     {14'd0, mode});
        write_reg(bmpc_pkg::CFG_STEP_PER_100MS, step);
        write_reg(bmpc_pkg::CFG_END_UP,         top_end);
        write_reg(bmpc_pkg::CFG_END_DOWN,       bottom_end);
        write_reg(bmpc_pkg::CFG_OVERDRIVE_UP,   top_od);
        write_reg(bmpc_pkg::CFG_OVERDRIVE_DOWN, bottom_od);
        write_reg(bmpc_pkg::CFG_SETTLE_MS,      settle);
        write_reg(bmpc_pkg::CFG_PREPARE_MS,     prepare);
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    // Mostly coherent traffic: time moves forward (wrapping), ticks dominate
    // so runs start and end, commands retarget at any stage. A small share is
    // noise with a random timestamp. span_ms sets the scale of time steps.
    task automatic run_random_phase(input int n_items, input int span_ms);
        int          k;
        int          pick;
        int unsigned adv;
        logic [1:0]  cmd;
        logic        forced;
        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 55)      adv = $urandom_range(span_ms / 4);
            else if (pick < 90) adv = $urandom_range(span_ms * 2);
            else if (pick < 98) adv = $urandom_range(200000);
            else                adv = $urandom;
            clock_ms = clock_ms + adv;
            forced   = 1'($urandom_range(1));
            pick     = $urandom_range(99);
            if (pick < 2) begin
                cmd = 2'($urandom_range(bmpc_pkg::CMD_TICK, bmpc_pkg::CMD_DOWN));
                send_item(cmd, forced, $urandom);
            end else if (pick < 72) begin
                send_item(bmpc_pkg::CMD_TICK, forced, clock_ms);
            end else begin
                cmd = 2'($urandom_range(bmpc_pkg::CMD_UP, bmpc_pkg::CMD_DOWN));
                send_item(cmd, forced, clock_ms);
            end
        end
    endtask

    initial begin
        int          settle;
        int          prepare;
        logic [15:0] top_end;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed walk at reset settings: 218 per 100 ms, settle 1000, prepare 100
        send_idle_pct <= 20;
        recv_idle_pct <= 66;
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd0);         // standstill, settle not over
        send_item(bmpc_pkg::CMD_UP,   1'b0, 32'hFFFF_FFFF); // up from mid-travel: far end
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'hFFFF_FFFF); // settle over: prepare up
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd40);        // prepare not over (wrapped)
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd110);       // up run starts
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd510);       // running, far from target
        send_item(bmpc_pkg::CMD_DOWN, 1'b0, 32'd610);       // command while running
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd700);       // normal stop
        send_item(bmpc_pkg::CMD_DOWN, 1'b1, 32'd800);       // forced down at standstill
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd1800);      // prepare down
        send_item(bmpc_pkg::CMD_UP,   1'b0, 32'd1850);      // command while preparing
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd1900);      // down run starts anyway
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd2000);      // passes target: normal stop
        send_item(bmpc_pkg::CMD_DOWN, 1'b0, 32'd2100);      // down to the far end
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd3100);
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd3200);      // down run starts
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd3300);      // down run short of target
        send_item(bmpc_pkg::CMD_STOP, 1'b0, 32'd3400);      // stop: target at estimate
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd5400);      // overshoot: reverse stop
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd6400);      // prepare up back to target
        send_item(bmpc_pkg::CMD_TICK, 1'b1, 32'hFFFF_FFFF); // up run starts
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd300);       // elapsed across the wrap
        send_item(bmpc_pkg::CMD_UP,   1'b0, 32'd350);       // retarget to estimate while up
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd2000);      // overshoot: reverse stop
        send_item(bmpc_pkg::CMD_UP,   1'b0, 32'd2100);
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd3100);
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd3200);
        send_item(bmpc_pkg::CMD_TICK, 1'b0, 32'd900000);    // clamps at overdrive
        send_item(bmpc_pkg::CMD_UP,   1'b0, 32'd900100);    // already up, not forced
        drain_results;

        // --- random phases over a spread of register settings
        clock_ms = $urandom;
        program_settings(bmpc_pkg::MODE_INTLK_UP, 16'd3000, 16'd2000, 16'd63535,
                         16'd0, 16'd65535, 16'd200, 16'd50);
        run_random_phase(ITEMS_PER_PHASE, 400);
        drain_results;

        program_settings(bmpc_pkg::MODE_INTLK_DOWN, 16'd9000, 16'd10000, 16'd50000,
                         16'd5000, 16'd60000, 16'd0, 16'd0);
        run_random_phase(ITEMS_PER_PHASE, 200);
        drain_results;

        send_idle_pct <= 66;
        recv_idle_pct <= 20;
        // reserved relay code with every length at its top value
        program_settings(bmpc_pkg::MODE_RESERVED, 16'hFFFF, 16'd0, 16'hFFFF,
                         16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random_phase(ITEMS_PER_PHASE, 65535);
        drain_results;

        // zero step: the estimate never moves, runs end only by retarget
        program_settings(bmpc_pkg::MODE_TWO_PHASE, 16'd0, 16'd2000, 16'd63535,
                         16'd1000, 16'd64000, 16'd10, 16'd10);
        run_random_phase(ITEMS_PER_PHASE, 100);
        drain_results;

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        settle  = $urandom_range(0, 2000);
        prepare = $urandom_range(0, 2000);
        top_end = 16'($urandom_range(0, 30000));
        program_settings(2'($urandom_range(bmpc_pkg::MODE_TWO_PHASE, bmpc_pkg::MODE_RESERVED)),
                         16'($urandom_range(1, 20000)), top_end,
                         16'($urandom_range(35000, 65535)),
                         16'($urandom_range(0, top_end)), 16'($urandom_range(35000, 65535)),
                         16'(settle), 16'(prepare));
        pressure_go <= 1'b1;
        run_random_phase(ITEMS_PER_PHASE, (settle > prepare ? settle : prepare) + 100);
        drain_results;

        // inverted ends and overdrives, smallest nonzero step
        program_settings(bmpc_pkg::MODE_INTLK_DOWN, 16'd1, 16'hFFFF, 16'd0,
                         16'hFFFF, 16'd0, 16'd100, 16'd100);
        run_random_phase(ITEMS_PER_PHASE, 200);
        drain_results;

        settle  = $urandom_range(0, 2000);
        prepare = $urandom_range(0, 2000);
        program_settings(2'($urandom_range(bmpc_pkg::MODE_TWO_PHASE, bmpc_pkg::MODE_RESERVED)),
                         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'(settle), 16'(prepare));
        run_random_phase(ITEMS_PER_PHASE, (settle > prepare ? settle : prepare) + 100);
        drain_results;

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items under %0d register settings across all relay modes",
                 items_sent, settings_done + 1);
        $display("  %0d results compared, %0d runs started, %0d runs ended, %0d mismatches",
                 checked, run_starts, run_ends, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bmpc_pkg.sv
rtl/core/bmpc_div100.sv
rtl/core/blind_motor_position_controller_core.sv
tb/bmpc_status_checker.sv
tb/blind_motor_position_controller_core_tb.sv
